[hdl/erc_pkg.sv]
// Shared types and constants for the event ring with sequence cursor.
// No dependencies.
package erc_pkg;

	localparam logic OP_EMIT  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] tick;
		logic [7:0]  disk;
		logic [7:0]  part;
		logic [47:0] blocks;
		logic [7:0]  op;
		logic [31:0] name;
	} erc_rec_t;

	typedef struct packed {
		logic cap_in;
		logic do_emit;
		logic scan_init;
		logic scan_step;
		logic load_out;
	} erc_cmd_t;

	typedef struct packed {
		logic is_fetch;
		logic scan_done;
		logic out_free;
	} erc_sts_t;

endpackage

[hdl/event_ring_with_seq_cursor_unit.sv]
// Event ring with sequence cursor: overwriting ring of event records.
// Emit: record written in exec state, result loaded in finish state. Fetch: result loaded
// after the one-read-per-cycle scan of the record RAM from oldest entry; a hit ends it early.
// Next transaction accepted only once the result is loaded; loading waits on a stalled output.
// Asynchronous active-low reset clears pointers, counters and handshake state; no RAM clear.
// Depends on erc_pkg, erc_ctrl, erc_dp, erc_ram.
module event_ring_with_seq_cursor_unit #(
	parameter int RING_DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [31:0]                       cursor,
	input  logic [7:0]                        disk_id,
	input  logic [7:0]                        part_id,
	input  logic [47:0]                       block_count,
	input  logic [31:0]                       now_tick,
	input  logic [7:0]                        op_tag,
	input  logic [31:0]                       name_tag,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [31:0]                       rec_seq,
	output logic [31:0]                       rec_tick,
	output logic [7:0]                        rec_disk,
	output logic [7:0]                        rec_part,
	output logic [47:0]                       rec_blocks,
	output logic [7:0]                        rec_op_tag,
	output logic [31:0]                       rec_name_tag,
	output logic [$clog2(RING_DEPTH + 1)-1:0] pending_count,
	output logic [31:0]                       dropped_count,
	output logic [31:0]                       latest_seq
);

	erc_pkg::erc_cmd_t cmd;
	erc_pkg::erc_sts_t sts;
	erc_pkg::erc_rec_t out_rec;

	erc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	erc_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.cursor        (cursor),
		.disk_id       (disk_id),
		.part_id       (part_id),
		.block_count   (block_count),
		.now_tick      (now_tick),
		.op_tag        (op_tag),
		.name_tag      (name_tag),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.out_rec       (out_rec),
		.pending_count (pending_count),
		.dropped_count (dropped_count),
		.latest_seq    (latest_seq)
	);

	assign rec_seq      = out_rec.seq;
	assign rec_tick     = out_rec.tick;
	assign rec_disk     = out_rec.disk;
	assign rec_part     = out_rec.part;
	assign rec_blocks   = out_rec.blocks;
	assign rec_op_tag   = out_rec.op;
	assign rec_name_tag = out_rec.name;

endmodule

[hdl/erc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module erc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/erc_ctrl.sv]
// Controller state machine for the event ring: sequences accept, emit, scan and result.
// Depends on erc_pkg.
module erc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  erc_pkg::erc_sts_t  sts,
	output erc_pkg::erc_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EXEC   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_fetch) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					cmd.do_emit = 1'b1;
					state_d     = ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

[hdl/erc_dp.sv]
// Datapath for the event ring: record RAM, pointers, counters, scan and output register.
// Depends on erc_pkg and erc_ram.
module erc_dp #(
	parameter int RING_DEPTH = 32,
	parameter int PTR_W      = $clog2(RING_DEPTH),
	parameter int CNT_W      = $clog2(RING_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  erc_pkg::erc_cmd_t  cmd,
	output erc_pkg::erc_sts_t  sts,
	input  logic               opcode,
	input  logic [31:0]        cursor,
	input  logic [7:0]         disk_id,
	input  logic [7:0]         part_id,
	input  logic [47:0]        block_count,
	input  logic [31:0]        now_tick,
	input  logic [7:0]         op_tag,
	input  logic [31:0]        name_tag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output erc_pkg::erc_rec_t  out_rec,
	output logic [CNT_W-1:0]   pending_count,
	output logic [31:0]        dropped_count,
	output logic [31:0]        latest_seq
);

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);

	logic              op_q;
	logic [31:0]       cur_q;
	erc_pkg::erc_rec_t in_rec_q;

	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  fill_q;
	logic [31:0]       drop_q;
	logic [31:0]       seq_q;

	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  issued_q;
	logic              dvld_q;
	logic              hit_q;
	erc_pkg::erc_rec_t hit_rec_q;

	logic              out_vld_q;
	logic              found_q;
	erc_pkg::erc_rec_t out_rec_q;
	logic [CNT_W-1:0]  pend_q;
	logic [31:0]       dropped_q;
	logic [31:0]       latest_q;

	erc_pkg::erc_rec_t wr_rec;
	erc_pkg::erc_rec_t rd_rec;
	logic              hit_now;
	logic              issue;
	logic              full;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	assign full    = (fill_q == FULL_CNT);
	assign hit_now = cmd.scan_step && dvld_q && (rd_rec.seq > cur_q);
	assign issue   = cmd.scan_step && (issued_q != fill_q) && !hit_now;

	always_comb begin
		wr_rec     = in_rec_q;
		wr_rec.seq = seq_q + 32'd1;
	end

	erc_ram #(
		.WIDTH ($bits(erc_pkg::erc_rec_t)),
		.DEPTH (RING_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.do_emit),
		.waddr (head_q),
		.wdata (wr_rec),
		.re    (issue),
		.raddr (rd_ptr_q),
		.rdata (rd_rec)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q            <= opcode;
			cur_q           <= cursor;
			in_rec_q.seq    <= '0;
			in_rec_q.tick   <= now_tick;
			in_rec_q.disk   <= disk_id;
			in_rec_q.part   <= part_id;
			in_rec_q.blocks <= block_count;
			in_rec_q.op     <= op_tag;
			in_rec_q.name   <= name_tag;
		end
		if (hit_now) begin
			hit_rec_q <= rd_rec;
		end
		if (cmd.load_out) begin
			found_q   <= hit_q;
			out_rec_q <= hit_q ? hit_rec_q : '0;
			pend_q    <= fill_q;
			dropped_q <= drop_q;
			latest_q  <= seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			drop_q    <= '0;
			seq_q     <= '0;
			rd_ptr_q  <= '0;
			issued_q  <= '0;
			dvld_q    <= 1'b0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.cap_in) begin
				hit_q <= 1'b0;
			end
			if (cmd.do_emit) begin
				seq_q  <= seq_q + 32'd1;
				head_q <= next_slot(head_q);
				if (full) begin
					tail_q <= next_slot(tail_q);
					drop_q <= drop_q + 32'd1;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.scan_init) begin
				rd_ptr_q <= tail_q;
				issued_q <= '0;
				dvld_q   <= 1'b0;
			end else if (cmd.scan_step) begin
				dvld_q <= issue;
				if (issue) begin
					rd_ptr_q <= next_slot(rd_ptr_q);
					issued_q <= issued_q + CNT_W'(1);
				end
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign sts.is_fetch  = (op_q == erc_pkg::OP_FETCH);
	assign sts.scan_done = hit_now || (issued_q == fill_q);
	assign sts.out_free  = !out_vld_q || !out_stall;

	assign out_valid     = out_vld_q;
	assign found         = found_q;
	assign out_rec       = out_rec_q;
	assign pending_count = pend_q;
	assign dropped_count = dropped_q;
	assign latest_seq    = latest_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count above ring depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == FULL_CNT) |-> (head_q == tail_q))
		else $error("head and tail disagree with fill count");

	a_drop_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_emit && full) |=> (drop_q == $past(drop_q) + 32'd1))
		else $error("overwrite of full ring did not count a drop");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (issued_q <= fill_q))
		else $error("scan read past filled entries");
`endif

endmodule
